### rtl/debug_packet_deframer_checksum_defines.svh
// Assertion macros shared by the checker of the packet deframer.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef DEBUG_PACKET_DEFRAMER_CHECKSUM_DEFINES_SVH
`define DEBUG_PACKET_DEFRAMER_CHECKSUM_DEFINES_SVH

// Same-cycle implication, quiet while reset is held.
`define DPDC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet while reset is held.
`define DPDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/dpdc_pkg.sv
// Shared types and constants of the debug packet deframer.
// No dependencies; used by the framing state machine, the top level and the checker.
package dpdc_pkg;

  localparam int unsigned MAX_PAYLOAD = 4096;
  localparam int unsigned CNT_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned LEN_W       = 13;

  localparam logic [7:0] CH_START = 8'h24;  // '$'
  localparam logic [7:0] CH_END   = 8'h23;  // '#'
  localparam logic [7:0] CH_BREAK = 8'h03;  // interrupt request
  localparam logic [7:0] CH_ACK   = 8'h2B;  // '+', dropped while idle like any stray byte
  localparam logic [3:0] HEX_TEN  = 4'hA;

  typedef enum logic [2:0] {
    KIND_DATA  = 3'd0,
    KIND_GOOD  = 3'd1,
    KIND_BAD   = 3'd2,
    KIND_OVER  = 3'd3,
    KIND_BREAK = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       data_byte;
    logic [LEN_W-1:0] packet_length;
    logic [7:0]       checksum_seen;
  } result_t;

endpackage

### rtl/debug_packet_deframer_checksum.sv
// Remote-debug packet deframer with checksum check. Each input word is one received
// byte; packets look like '$' payload '#' h h. While idle, stray bytes and '+' acks
// are dropped and a 0x03 byte yields a break word. Every payload byte up to
// MAX_PAYLOAD is passed on at once as a data word; the trailer yields a good or bad
// verdict carrying the payload length and the received checksum. A payload that
// exceeds MAX_PAYLOAD bytes yields an overflow word and the deframer returns to
// idle. The framing state updates in the cycle a byte is accepted and its
// result lands in the output register on the same edge, so a byte can be taken
// every cycle while the output is not stalled. in_tready is low only while the
// output register holds a word that the sink has not taken; a result shows in the
// cycle after its byte is accepted. Depends on dpdc_pkg and dpdc_fsm.
module debug_packet_deframer_checksum (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] data_byte, [20:8] packet_length,
                                  // [28:21] checksum_seen, [31:29] zero
  output logic [2:0]  out_tuser   // [2:0] kind
);
  import dpdc_pkg::*;

  logic    accept;
  logic    res_valid;
  result_t res;
  logic    out_valid_r;
  result_t out_r;

  // The output register frees itself in the same cycle the sink takes its word.
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  dpdc_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .rx_byte   (in_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= accept && res_valid;
    end
    if (accept && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.kind;
  assign out_tdata  = {3'b000, out_r.checksum_seen, out_r.packet_length, out_r.data_byte};

endmodule

### rtl/dpdc_fsm.sv
// Framing state machine: phase, running sum, checksum digit and payload length.
// Depends on dpdc_pkg; produces at most one result per accepted byte, combinationally.
module dpdc_fsm (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        rx_byte,
  output logic              res_valid,
  output dpdc_pkg::result_t res
);
  import dpdc_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_HI      = 2'd2,
    PH_LO      = 2'd3
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [3:0]       nibble_r, nibble_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [3:0]       digit;
  logic [7:0]       cks;

  // Hex digit value; anything that is not a hex digit counts as zero.
  always_comb begin
    if (rx_byte >= 8'h30 && rx_byte <= 8'h39) begin
      digit = rx_byte[3:0];
    end else if ((rx_byte >= 8'h61 && rx_byte <= 8'h66) ||
                 (rx_byte >= 8'h41 && rx_byte <= 8'h46)) begin
      digit = rx_byte[3:0] - 4'd1 + HEX_TEN;
    end else begin
      digit = 4'd0;
    end
  end

  assign cks = {nibble_r, digit};

  always_comb begin
    phase_nxt  = phase_r;
    sum_nxt    = sum_r;
    nibble_nxt = nibble_r;
    count_nxt  = count_r;
    res_valid  = 1'b0;
    res        = '{kind: KIND_DATA, data_byte: 8'd0, packet_length: '0,
                   checksum_seen: 8'd0};
    case (phase_r)
      PH_IDLE: begin
        if (rx_byte == CH_START) begin
          phase_nxt = PH_PAYLOAD;
          sum_nxt   = 8'd0;
          count_nxt = '0;
        end else if (rx_byte == CH_BREAK) begin
          res_valid = 1'b1;
          res.kind  = KIND_BREAK;
        end
      end
      PH_PAYLOAD: begin
        if (rx_byte == CH_END) begin
          phase_nxt = PH_HI;
        end else if (count_r == CNT_W'(MAX_PAYLOAD)) begin
          phase_nxt         = PH_IDLE;
          res_valid         = 1'b1;
          res.kind          = KIND_OVER;
          res.packet_length = LEN_W'(count_r);
        end else begin
          sum_nxt       = sum_r + rx_byte;
          count_nxt     = count_r + CNT_W'(1);
          res_valid     = 1'b1;
          res.data_byte = rx_byte;
        end
      end
      PH_HI: begin
        nibble_nxt = digit;
        phase_nxt  = PH_LO;
      end
      PH_LO: begin
        phase_nxt         = PH_IDLE;
        res_valid         = 1'b1;
        res.kind          = (cks == sum_r) ? KIND_GOOD : KIND_BAD;
        res.packet_length = LEN_W'(count_r);
        res.checksum_seen = cks;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else if (accept) begin
      phase_r <= phase_nxt;
    end
    if (accept) begin
      sum_r    <= sum_nxt;
      nibble_r <= nibble_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### rtl/dpdc_checker.sv
// Port-level checker for the packet deframer, attached to the top level by bind.
// Depends on dpdc_pkg and the assertion macros in the shared header.
`include "debug_packet_deframer_checksum_defines.svh"

module dpdc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [2:0]  out_tuser
);
  import dpdc_pkg::*;

  // An offered input word stays put until the deframer takes it.
  `DPDC_ASSERT_NEXT(a_in_hold, in_tvalid && !in_tready,
    in_tvalid && $stable(in_tdata), "offered input word changed before acceptance")

  // A word the sink has not taken stays put.
  `DPDC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled output word changed")

  // Input back-pressure comes only from a stalled output register.
  `DPDC_ASSERT_NOW(a_ready_cause, !in_tready, out_tvalid && !out_tready,
    "input stalled without a stalled output")

  // Data words carry no length or checksum.
  `DPDC_ASSERT_NOW(a_data_clean, out_tvalid && out_tuser == KIND_DATA,
    out_tdata[31:8] == 24'd0, "data word carries length or checksum bits")

  // A break word is all zero apart from its kind.
  `DPDC_ASSERT_NOW(a_break_clean, out_tvalid && out_tuser == KIND_BREAK,
    out_tdata == 32'd0, "break word carries payload bits")

endmodule

bind debug_packet_deframer_checksum dpdc_checker u_dpdc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

### sim/debug_packet_deframer_checksum_tb.sv
// Self-checking testbench of the remote-debug packet deframer with checksum check.
// It drives received bytes in, predicts each output word and compares it field by field.
// Depends on dpdc_pkg and debug_packet_deframer_checksum.
`timescale 1ns / 100ps

module debug_packet_deframer_checksum_tb;
  import dpdc_pkg::*;

  // Deframer phases as the predictor tracks them.
  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_HI      = 2'd2,
    PH_LO      = 2'd3
  } link_phase_t;

  // ASCII anchors for building and decoding hex digits.
  localparam logic [7:0] CHR_ZERO    = 8'h30;
  localparam logic [7:0] CHR_NINE    = 8'h39;
  localparam logic [7:0] CHR_UPPER_A = 8'h41;
  localparam logic [7:0] CHR_UPPER_F = 8'h46;
  localparam logic [7:0] CHR_LOWER_A = 8'h61;
  localparam logic [7:0] CHR_LOWER_F = 8'h66;

  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 150;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;    // [7:0] rx_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;           // [7:0] data_byte, [20:8] packet_length,
                                    // [28:21] checksum_seen, [31:29] zero
  logic [2:0]  out_tuser;           // [2:0] kind

  // Predictor state: our own copy of the framing state machine.
  link_phase_t fr_phase = PH_IDLE;
  logic [7:0]  fr_sum = 8'h00;
  logic [3:0]  fr_hi = 4'h0;
  int unsigned fr_count = 0;

  // Words the deframer still owes us, oldest first.
  result_t     expected_words[$];
  logic [7:0]  pkt_payload[$];

  int unsigned error_count = 0;
  int unsigned useful_words = 0;

  // Idle percentages of both sides, changed between phases of the run.
  int unsigned src_idle_pct = 0;
  int unsigned sink_idle_pct = 0;

  // A long sink hold-off is requested by bumping hold_req; the sink process
  // owns hold_ack and the countdown, so each variable has a single writer.
  int unsigned hold_req = 0;
  int unsigned hold_ack = 0;
  int unsigned hold_left = 0;

  debug_packet_deframer_checksum dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // Hard limit on the run.
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  // Value of one checksum character; anything that is not a hex digit counts as zero.
  // Digits and both letter ranges are decoded from the low nibble of the code.
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    if (c >= CHR_ZERO && c <= CHR_NINE) return c[3:0];
    if (c >= CHR_LOWER_A && c <= CHR_LOWER_F) return c[3:0] + 4'd9;
    if (c >= CHR_UPPER_A && c <= CHR_UPPER_F) return c[3:0] + 4'd9;
    return 4'h0;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
    if (nib < HEX_TEN) return CHR_ZERO + 8'(nib);
    return (upper ? CHR_UPPER_A : CHR_LOWER_A) + 8'(nib - HEX_TEN);
  endfunction

  // Advances the predicted framing state by one received byte and tells
  // whether that byte produces an output word, and which one.
  function automatic void deframe_step(input logic [7:0] b, output bit has_word,
                                       output result_t word);
    logic [7:0] cks;
    has_word = 1'b0;
    word = '0;
    case (fr_phase)
      PH_IDLE: begin
        if (b == CH_START) begin
          fr_phase = PH_PAYLOAD;
          fr_sum = 8'h00;
          fr_count = 0;
        end else if (b == CH_BREAK) begin
          has_word = 1'b1;
          word.kind = KIND_BREAK;
        end
      end
      PH_PAYLOAD: begin
        if (b == CH_END) begin
          fr_phase = PH_HI;
        end else if (fr_count >= MAX_PAYLOAD) begin
          // The byte past a full payload is dropped and framing starts over.
          has_word = 1'b1;
          word.kind = KIND_OVER;
          word.packet_length = fr_count[LEN_W-1:0];
          fr_phase = PH_IDLE;
        end else begin
          fr_sum = fr_sum + b;
          fr_count = fr_count + 1;
          has_word = 1'b1;
          word.kind = KIND_DATA;
          word.data_byte = b;
        end
      end
      PH_HI: begin
        fr_hi = hex_value(b);
        fr_phase = PH_LO;
      end
      default: begin
        cks = {fr_hi, hex_value(b)};
        fr_phase = PH_IDLE;
        has_word = 1'b1;
        word.kind = (cks == fr_sum) ? KIND_GOOD : KIND_BAD;
        word.packet_length = fr_count[LEN_W-1:0];
        word.checksum_seen = cks;
      end
    endcase
  endfunction

  // Offers one byte, with random idle cycles first, and waits for the handshake.
  // in_tvalid stays high after the handshake so back-to-back words need no toggle.
  task automatic send_word(input logic [7:0] b);
    bit      has_word;
    result_t word;
    bit      ignored;
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    ignored = (fr_phase == PH_IDLE) && (b != CH_START) && (b != CH_BREAK);
    deframe_step(b, has_word, word);
    if (has_word) expected_words.push_back(word);
    if (!ignored) useful_words++;
  endtask

  // Sender pause: nothing is offered until every predicted word has arrived.
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_words.size() != 0);
  endtask

  // Random payload of n bytes with no '#', biased toward the control bytes.
  task automatic fill_payload(input int unsigned n);
    logic [7:0] b;
    pkt_payload.delete();
    repeat (n) begin
      case ($urandom_range(7))
        0: b = CH_START;
        1: b = CH_ACK;
        2: b = CH_BREAK;
        default: b = 8'($urandom_range(255));
      endcase
      if (b == CH_END) b = 8'h00;
      pkt_payload.push_back(b);
    end
  endtask

  // Sends '$' pkt_payload '#' hh; with corrupt set the checksum is off by a nonzero mask.
  task automatic send_packet(input bit corrupt);
    logic [7:0] sum;
    sum = 8'h00;
    foreach (pkt_payload[i]) sum = sum + pkt_payload[i];
    if (corrupt) sum = sum ^ 8'($urandom_range(1, 255));
    send_word(CH_START);
    foreach (pkt_payload[i]) send_word(pkt_payload[i]);
    send_word(CH_END);
    send_word(hex_char(sum[7:4], 1'($urandom_range(1))));
    send_word(hex_char(sum[3:0], 1'($urandom_range(1))));
  endtask

  // Closes whatever packet is open so the next test starts from idle.
  task automatic return_to_idle();
    while (fr_phase != PH_IDLE) send_word(fr_phase == PH_PAYLOAD ? CH_END : CHR_ZERO);
  endtask

  // Idle-state handling: acks and stray bytes vanish, 0x03 gives a break word.
  task automatic test_idle_bytes();
    send_word(CH_ACK);
    send_word(8'h00);
    send_word(8'hFF);
    send_word(CH_BREAK);
    send_word(8'h78);
  endtask

  // "$#00": a verdict with zero length and zero sum.
  task automatic test_empty_packet();
    pkt_payload.delete();
    send_packet(1'b0);
  endtask

  // '$', '+', 0x03 and the byte extremes inside a payload are plain data.
  task automatic test_control_bytes_in_payload();
    pkt_payload = '{CH_START, CH_ACK, CH_BREAK, 8'hFF, 8'h00};
    send_packet(1'b0);
  endtask

  // Invalid digits read as zero (here that matches a zero sum), and a mixed-case
  // trailer that does not match the sum gives a bad verdict.
  task automatic test_checksum_digits();
    send_word(CH_START);
    send_word(8'h00);
    send_word(CH_END);
    send_word(8'h67);   // 'g'
    send_word(8'h5A);   // 'Z'
    send_word(CH_START);
    send_word(8'hAB);
    send_word(CH_END);
    send_word(CHR_LOWER_A);
    send_word(8'h43);   // 'C'
  endtask

  // A payload of exactly MAX_PAYLOAD bytes still gets a verdict.
  task automatic test_max_length_packet();
    fill_payload(MAX_PAYLOAD);
    send_packet(1'b0);
  endtask

  // One byte past MAX_PAYLOAD gives an overflow word; the trailer that follows
  // then lands in the idle state and is dropped as stray bytes.
  task automatic test_payload_overflow();
    logic [7:0] extra;
    fill_payload(MAX_PAYLOAD);
    send_word(CH_START);
    foreach (pkt_payload[i]) send_word(pkt_payload[i]);
    extra = 8'($urandom_range(255));
    if (extra == CH_END) extra = CH_START;
    send_word(extra);
    send_word(CH_END);
    send_word(hex_char(4'h1, 1'b0));
    send_word(hex_char(4'h2, 1'b0));
  endtask

  // The sink holds off for a long stretch while a packet keeps coming, so the
  // output register fills and in_tready drops; then everything drains.
  task automatic test_backpressure();
    hold_req = hold_req + 1;
    fill_payload(40);
    send_packet(1'b0);
    wait_for_results();
  endtask

  // Mostly well-formed packets with random content and length; the rest is
  // stray bytes, breaks, broken trailers and packets left open, which the next bytes continue.
  task automatic test_random_traffic(input int unsigned n_words);
    int unsigned target;
    int unsigned pick;
    target = useful_words + n_words;
    while (useful_words < target) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        fill_payload(($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(16));
        send_packet($urandom_range(9) == 0);
      end else if (pick < 75) begin
        repeat ($urandom_range(1, 4))
          send_word(($urandom_range(3) == 0) ? CH_ACK : 8'($urandom_range(255)));
      end else if (pick < 82) begin
        send_word(CH_BREAK);
      end else if (pick < 92) begin
        // Arbitrary trailer bytes: invalid digits, digits of either case, anything.
        fill_payload($urandom_range(8));
        send_word(CH_START);
        foreach (pkt_payload[i]) send_word(pkt_payload[i]);
        send_word(CH_END);
        send_word(8'($urandom_range(255)));
        send_word(8'($urandom_range(255)));
      end else begin
        // Truncated packet: the next packet's bytes continue its payload.
        fill_payload($urandom_range(6));
        send_word(CH_START);
        foreach (pkt_payload[i]) send_word(pkt_payload[i]);
      end
    end
    return_to_idle();
    wait_for_results();
  endtask

  // Sink side: random stalls, or a counted hold-off when one is requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Every accepted output word is checked against the oldest prediction.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: kind %0d, tdata 0x%08h", out_tuser, out_tdata);
        error_count++;
      end else begin
        want = expected_words.pop_front();
        if (out_tuser !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, out_tuser);
          error_count++;
        end
        if (out_tdata[7:0] !== want.data_byte) begin
          $error("data_byte: expected 0x%02h, actual 0x%02h", want.data_byte, out_tdata[7:0]);
          error_count++;
        end
        if (out_tdata[20:8] !== want.packet_length) begin
          $error("packet_length: expected %0d, actual %0d", want.packet_length,
                 out_tdata[20:8]);
          error_count++;
        end
        if (out_tdata[28:21] !== want.checksum_seen) begin
          $error("checksum_seen: expected 0x%02h, actual 0x%02h", want.checksum_seen,
                 out_tdata[28:21]);
          error_count++;
        end
        if (out_tdata[31:29] !== 3'b000) begin
          $error("tdata padding: expected 0, actual %0d", out_tdata[31:29]);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Phase one: sender idles now and then, sink stalls more than half the time.
    src_idle_pct = 31;
    sink_idle_pct = 57;
    test_idle_bytes();
    test_empty_packet();
    test_control_bytes_in_payload();
    test_checksum_digits();
    wait_for_results();
    test_random_traffic(580);
    test_backpressure();

    // Phase two: the roles swap.
    src_idle_pct = 57;
    sink_idle_pct = 31;
    test_random_traffic(580);
    test_backpressure();

    // Phase three: full rate both ways, including the long packets.
    src_idle_pct = 0;
    sink_idle_pct = 0;
    test_max_length_packet();
    test_payload_overflow();
    wait_for_results();
    test_random_traffic(590);

    in_tvalid <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_words.size() != 0) begin
      $error("%0d predicted words never arrived", expected_words.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/dpdc_pkg.sv
rtl/dpdc_fsm.sv
rtl/debug_packet_deframer_checksum.sv
rtl/dpdc_checker.sv
sim/debug_packet_deframer_checksum_tb.sv
